// ----- hw/rtl/qpt_pkg.sv -----
`default_nettype none

package qpt_pkg;

	// Field and register widths
	localparam int POSITION_BITS_DEF = 32;
	localparam int MOD_BITS          = 20;
	localparam int TOL_BITS          = 20;
	localparam int TARGET_BITS       = 32;
	localparam int WINDOW_BITS       = 24;
	localparam int LEVEL_BITS        = 9;
	localparam int PWM_BITS          = 8;
	localparam int ACTION_BITS       = 2;
	localparam int DATA_BITS         = 32;
	localparam int ADDR_BITS         = 5;
	localparam int IDX_BITS          = 3;

	// Item kinds
	localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_TICK   = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_DRIVE  = 2'd2;

	// Register indexes
	localparam logic [IDX_BITS-1:0] REG_STEPS  = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_TOL    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_PARK   = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_HOME   = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_WINDOW = 3'd4;

	// Register reset values
	localparam logic [MOD_BITS-1:0]    STEPS_RST  = 20'd96967;
	localparam logic [TOL_BITS-1:0]    TOL_RST    = 20'd1000;
	localparam logic [TARGET_BITS-1:0] PARK_RST   = 32'd0;
	localparam logic [TARGET_BITS-1:0] HOME_RST   = 32'd0;
	localparam logic [WINDOW_BITS-1:0] WINDOW_RST = 24'd500000;

	// Drive ramp
	localparam logic signed [LEVEL_BITS:0]   RAMP_STEP = 10'sd10;
	localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = -9'sd255;
	localparam logic signed [LEVEL_BITS-1:0] LEVEL_LOW = -9'sd256;

	typedef struct packed {
		logic [MOD_BITS-1:0]    steps;
		logic [TOL_BITS-1:0]    tol;
		logic [TARGET_BITS-1:0] park;
		logic [TARGET_BITS-1:0] home;
		logic [WINDOW_BITS-1:0] window;
	} qpt_cfg_t;

	// Quadrature step, indexed by {next phase, previous phase}
	localparam logic signed [1:0] STEP_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd0, 2'sd1,
		2'sd1, 2'sd0, -2'sd1, 2'sd0,
		2'sd0, 2'sd1, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd1, 2'sd0
	};

	// AB = 11 -> 0, 10 -> 1, 00 -> 2, 01 -> 3
	function automatic logic [1:0] phase_code(input logic a, input logic b);
		logic [1:0] c;
		if (a && b) c = 2'd0;
		else if (a) c = 2'd1;
		else if (!b) c = 2'd2;
		else c = 2'd3;
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/qpt_cfg_regs.sv -----
`default_nettype none

module qpt_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [qpt_pkg::ADDR_BITS-1:0]  paddr,
	input  wire logic [qpt_pkg::DATA_BITS-1:0]  pwdata,
	output logic      [qpt_pkg::DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output qpt_pkg::qpt_cfg_t                   cfg
);

	logic [qpt_pkg::IDX_BITS-1:0] idx;
	logic                         wr_en;
	qpt_pkg::qpt_cfg_t            cfg_q;

	assign idx    = paddr[qpt_pkg::ADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps  <= qpt_pkg::STEPS_RST;
			cfg_q.tol    <= qpt_pkg::TOL_RST;
			cfg_q.park   <= qpt_pkg::PARK_RST;
			cfg_q.home   <= qpt_pkg::HOME_RST;
			cfg_q.window <= qpt_pkg::WINDOW_RST;
		end else if (wr_en) begin
			case (idx)
				qpt_pkg::REG_STEPS:  cfg_q.steps  <= pwdata[qpt_pkg::MOD_BITS-1:0];
				qpt_pkg::REG_TOL:    cfg_q.tol    <= pwdata[qpt_pkg::TOL_BITS-1:0];
				qpt_pkg::REG_PARK:   cfg_q.park   <= pwdata[qpt_pkg::TARGET_BITS-1:0];
				qpt_pkg::REG_HOME:   cfg_q.home   <= pwdata[qpt_pkg::TARGET_BITS-1:0];
				qpt_pkg::REG_WINDOW: cfg_q.window <= pwdata[qpt_pkg::WINDOW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			qpt_pkg::REG_STEPS:  prdata = qpt_pkg::DATA_BITS'(cfg_q.steps);
			qpt_pkg::REG_TOL:    prdata = qpt_pkg::DATA_BITS'(cfg_q.tol);
			qpt_pkg::REG_PARK:   prdata = qpt_pkg::DATA_BITS'(cfg_q.park);
			qpt_pkg::REG_HOME:   prdata = qpt_pkg::DATA_BITS'(cfg_q.home);
			qpt_pkg::REG_WINDOW: prdata = qpt_pkg::DATA_BITS'(cfg_q.window);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/qpt_rem_serial.sv -----
`default_nettype none

// Bit-serial truncated remainder: magnitude shifted out MSB first, one
// restoring subtract per cycle. Sign of the dividend comes back as neg.
module qpt_rem_serial #(
	parameter int W = qpt_pkg::POSITION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [W-1:0]                  value,
	input  wire logic [qpt_pkg::MOD_BITS-1:0]  modulus,
	output logic                               busy,
	output logic      [qpt_pkg::MOD_BITS-1:0]  rem,
	output logic                               neg
);

	localparam int MB = qpt_pkg::MOD_BITS;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  mag_q;
	logic [MB-1:0] rem_q;
	logic [MB-1:0] mod_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [MB:0]   trial;
	logic [MB:0]   diff;
	logic          fits;

	// One restoring step
	assign trial = {rem_q, mag_q[W-1]};
	assign diff  = trial - {1'b0, mod_q};
	assign fits  = trial >= {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	// Datapath, loaded on start
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= value[W-1];
			mag_q <= value[W-1] ? (~value + 1'b1) : value;
			rem_q <= '0;
			mod_q <= (modulus == '0) ? MB'(1) : modulus;
		end else if (busy_q) begin
			mag_q <= {mag_q[W-2:0], 1'b0};
			rem_q <= fits ? diff[MB-1:0] : trial[MB-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;
	assign neg  = neg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/quadrature_position_tracker_top.sv -----
`default_nettype none

// Channel  Dir  Handshake                 Payload
// s        in   s_tvalid / s_tready       s_tuser action, s_tdata phases + drive target
// m        out  m_tvalid / m_tready       m_tdata position, delta, level, pwm, flags
// apb      in   psel, penable, pready=1   5 registers at byte address 4*i
//
// An item passes through the load, run and compare states from accept to result;
// the run state waits on the bit-serial remainder units, one dividend bit per cycle.
// The next item is taken once the result sits in the output register.
// A stalled output holds its beat; a finished item waits until it is free.
// Reset is asynchronous, active low, and clears all tracking state.
module quadrature_position_tracker_top #(
	parameter int POSITION_BITS = qpt_pkg::POSITION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input beats
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [1:0] action
	input  wire logic [1:0]                    s_tuser,
	// [0] phase_a, [1] phase_b, [10:2] drive_target, [15:11] zero
	input  wire logic [15:0]                   s_tdata,
	// result beats
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [31:0] position, [63:32] velocity_delta, [72:64] drive_level,
	// [80:73] pwm_right, [88:81] pwm_left, [89] at_park, [90] at_home, [95:91] zero
	output logic      [95:0]                   m_tdata,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [qpt_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [qpt_pkg::DATA_BITS-1:0] pwdata,
	output logic      [qpt_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready
);

	localparam int MB = qpt_pkg::MOD_BITS;
	localparam int LB = qpt_pkg::LEVEL_BITS;
	localparam int TB = qpt_pkg::TARGET_BITS;
	localparam int WB = qpt_pkg::WINDOW_BITS;

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_CMP} state_t;

	state_t state_q;

	qpt_pkg::qpt_cfg_t cfg;

	// tracking state
	logic [POSITION_BITS-1:0] pos_q;
	logic [1:0]               phase_q;
	logic                     primed_q;
	logic [WB-1:0]            ticks_q;
	logic [TB-1:0]            win_start_q;
	logic [TB-1:0]            delta_q;
	logic signed [LB-1:0]     level_q;
	logic signed [LB-1:0]     target_q;

	logic                     m_tvalid_q;
	logic [95:0]              m_tdata_q;

	// remainder units
	logic          div_start;
	logic          busy_pos, busy_park, busy_home;
	logic [MB-1:0] rem_pos, rem_park, rem_home;
	logic          neg_pos, neg_park, neg_home;

	qpt_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cfg(cfg)
	);

	qpt_rem_serial #(.W(POSITION_BITS)) u_rem_pos (
		.clk(clk), .arst_n(arst_n), .start(div_start), .value(pos_q),
		.modulus(cfg.steps), .busy(busy_pos), .rem(rem_pos), .neg(neg_pos)
	);

	qpt_rem_serial #(.W(TB)) u_rem_park (
		.clk(clk), .arst_n(arst_n), .start(div_start), .value(cfg.park),
		.modulus(cfg.steps), .busy(busy_park), .rem(rem_park), .neg(neg_park)
	);

	qpt_rem_serial #(.W(TB)) u_rem_home (
		.clk(clk), .arst_n(arst_n), .start(div_start), .value(cfg.home),
		.modulus(cfg.steps), .busy(busy_home), .rem(rem_home), .neg(neg_home)
	);

	// input fields
	logic [1:0]           in_action;
	logic                 in_a, in_b;
	logic signed [LB-1:0] in_target;
	logic                 accept;

	assign in_action = s_tuser;
	assign in_a      = s_tdata[0];
	assign in_b      = s_tdata[1];
	assign in_target = $signed(s_tdata[10:2]);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign div_start = (state_q == S_LOAD);

	// encoder step
	logic [1:0]        phase_nxt;
	logic signed [1:0] step_d;
	assign phase_nxt = qpt_pkg::phase_code(in_a, in_b);
	assign step_d    = qpt_pkg::STEP_TABLE[{phase_nxt, phase_q}];

	// position as 32-bit field, zero-extended from the counter
	logic [63:0]   pos_ext;
	logic [TB-1:0] pos32;
	assign pos_ext = 64'(pos_q);
	assign pos32   = pos_ext[TB-1:0];

	// tick counter
	logic [WB-1:0] ticks_inc;
	logic          win_done;
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
	assign win_done  = ticks_inc > cfg.window;

	// ramp toward target
	logic signed [LB:0]   lvl_w, tgt_w, lvl_up, lvl_dn, lvl_neg;
	logic signed [LB-1:0] level_nxt;
	assign lvl_w   = {level_q[LB-1], level_q};
	assign tgt_w   = {target_q[LB-1], target_q};
	assign lvl_up  = lvl_w + qpt_pkg::RAMP_STEP;
	assign lvl_dn  = lvl_w - qpt_pkg::RAMP_STEP;
	assign lvl_neg = -lvl_w;

	always_comb begin
		if (lvl_w < tgt_w) begin
			level_nxt = (lvl_up > tgt_w) ? target_q : lvl_up[LB-1:0];
		end else if (lvl_w > tgt_w) begin
			level_nxt = (lvl_dn < tgt_w) ? target_q : lvl_dn[LB-1:0];
		end else begin
			level_nxt = level_q;
		end
	end

	// duty split
	logic [qpt_pkg::PWM_BITS-1:0] pwm_r, pwm_l;
	assign pwm_r = level_q[LB-1] ? '0 : level_q[qpt_pkg::PWM_BITS-1:0];
	assign pwm_l = level_q[LB-1] ? lvl_neg[qpt_pkg::PWM_BITS-1:0] : '0;

	// signed remainders and distance test
	function automatic logic signed [MB+1:0] srem(input logic neg, input logic [MB-1:0] r);
		logic signed [MB+1:0] v;
		v = $signed({2'b00, r});
		return neg ? -v : v;
	endfunction

	logic signed [MB+1:0] a_pos, a_park, a_home, d_park, d_home;
	logic [MB+1:0]        abs_park, abs_home;
	logic                 near_park, near_home;

	assign a_pos    = srem(neg_pos, rem_pos);
	assign a_park   = srem(neg_park, rem_park);
	assign a_home   = srem(neg_home, rem_home);
	assign d_park   = a_park - a_pos;
	assign d_home   = a_home - a_pos;
	assign abs_park = d_park[MB+1] ? -d_park : d_park;
	assign abs_home = d_home[MB+1] ? -d_home : d_home;
	assign near_park = (target_q == '0) && (abs_park < {2'b00, cfg.tol});
	assign near_home = (target_q == '0) && (abs_home < {2'b00, cfg.tol});

	logic div_busy;
	logic out_free;
	assign div_busy = busy_pos || busy_park || busy_home;
	assign out_free = !m_tvalid_q || m_tready;

	// sequencer, tracking state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			phase_q     <= '0;
			primed_q    <= 1'b0;
			ticks_q     <= '0;
			win_start_q <= '0;
			delta_q     <= '0;
			level_q     <= '0;
			target_q    <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// result beat: load at compare, drop once taken
			if (state_q == S_CMP && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {5'b0, near_home, near_park, pwm_l, pwm_r,
					level_q, delta_q, pos32};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOAD;
						case (in_action)
							qpt_pkg::ACT_SAMPLE: begin
								if (primed_q)
									pos_q <= pos_q + POSITION_BITS'(step_d);
								phase_q  <= phase_nxt;
								primed_q <= 1'b1;
							end
							qpt_pkg::ACT_TICK: begin
								if (win_done) begin
									delta_q     <= pos32 - win_start_q;
									win_start_q <= pos32;
									ticks_q     <= '0;
								end else begin
									ticks_q <= ticks_inc;
								end
								level_q <= level_nxt;
							end
							qpt_pkg::ACT_DRIVE: begin
								target_q <= (in_target == qpt_pkg::LEVEL_LOW) ?
									qpt_pkg::LEVEL_MIN : in_target;
							end
							default: ;
						endcase
					end
				end
				S_LOAD: state_q <= S_RUN;
				S_RUN: begin
					if (!div_busy) state_q <= S_CMP;
				end
				S_CMP: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("remainder unit busy while taking input");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second beat taken while an item is in work");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_CMP))
		else $error("result beat raised outside the compare step");

endmodule

`default_nettype wire
